FILE: sv/ffcsa_pkg.sv
`timescale 1ns / 1ps

package ffcsa_pkg;

  localparam int MAX_RUN = 8;
  localparam int RUN_W   = 4;
  localparam int TAG_W   = 8;
  localparam int SIZE_W  = 5;
  localparam int POS_W   = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_FIT
  } state_t;

  typedef enum logic [1:0] {
    STATUS_GRANTED = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_BAD     = 2'd2
  } status_t;

  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
  } pend_entry_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [POS_W-1:0] pos;
  } grant_t;

endpackage

FILE: sv/ffcsa_fit.sv
`timescale 1ns / 1ps

module ffcsa_fit #(
  parameter int SLOT_COUNT = 16,
  parameter int IDX_W      = 4
) (
  input  logic [SLOT_COUNT-1:0]          busy_map,
  input  logic [ffcsa_pkg::SIZE_W-1:0]   run_len,
  output logic                           found,
  output logic [IDX_W-1:0]               first_idx,
  output logic [SLOT_COUNT-1:0]          claim_mask
);

  logic [SLOT_COUNT-1:0] fits;

  // window test at every start
  always_comb begin
    logic [SLOT_COUNT-1:0] win;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      for (int j = 0; j < SLOT_COUNT; j++) begin
        win[j] = (j >= i) && (j < i + int'(run_len));
      end
      fits[i] = (i + int'(run_len) <= SLOT_COUNT) && ((busy_map & win) == '0);
    end
  end

  // lowest start wins
  always_comb begin
    found     = 1'b0;
    first_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (fits[i]) begin
        found     = 1'b1;
        first_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < SLOT_COUNT; j++) begin
      claim_mask[j] = (j >= int'(first_idx)) && (j < int'(first_idx) + int'(run_len));
    end
  end

endmodule

FILE: sv/first_fit_contiguous_slot_allocator.sv
`timescale 1ns / 1ps

// channel   ports                                                        beat
// --------  -----------------------------------------------------------  ---------------------
// input     in_opcode in_requester_tag in_request_size in_release_start  start high, busy low
// result    out_status out_grant_tag out_grant_start out_last_of_run     out_valid, one cycle
//
// an accepted beat goes through the command check, then for each grant a pending queue
// memory read and a first-fit search; the run ends after at most 8 grants
// busy stays high through the run, plus a last failed search when the head does not fit
// an error beat ends at the check; the last result shows in the first cycle busy is low
// each grant is held until the next search so the last of a run can be marked
// reset empties the slot map and the pending queue at once; results cannot be stalled

module first_fit_contiguous_slot_allocator #(
  parameter int SLOT_COUNT  = 16,
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic [ffcsa_pkg::TAG_W-1:0]     in_requester_tag,
  input  logic [ffcsa_pkg::SIZE_W-1:0]    in_request_size,
  input  logic [ffcsa_pkg::POS_W-1:0]     in_release_start,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [ffcsa_pkg::TAG_W-1:0]     out_grant_tag,
  output logic [ffcsa_pkg::POS_W-1:0]     out_grant_start,
  output logic                            out_last_of_run
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = QW + 2;

  ffcsa_pkg::state_t state_r, state_nxt;

  logic [SLOT_COUNT-1:0]            map_r, map_nxt;
  logic [QW-1:0]                    head_r, head_nxt;
  logic [CW-1:0]                    count_r, count_nxt;
  logic [ffcsa_pkg::RUN_W-1:0]      run_r, run_nxt;

  logic                             op_r;
  ffcsa_pkg::pend_entry_t           cmd_r;
  logic [ffcsa_pkg::POS_W-1:0]      rel_start_r;

  logic                             hold_valid_r, hold_valid_nxt;
  ffcsa_pkg::grant_t                hold_r, hold_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [1:0]                       out_status_r, out_status_nxt;
  ffcsa_pkg::grant_t                out_r, out_nxt;
  logic                             out_last_r, out_last_nxt;

  ffcsa_pkg::pend_entry_t           mem [QUEUE_DEPTH];
  ffcsa_pkg::pend_entry_t           rd_data_r;
  logic                             mem_we, mem_re;
  logic [QW-1:0]                    mem_waddr;

  logic                             fit_found;
  logic [IDX_W-1:0]                 fit_idx;
  logic [SLOT_COUNT-1:0]            fit_claim;

  logic [SUM_W-1:0]                 tail_sum;
  logic [6:0]                       rel_end;
  logic                             rsv_bad, rel_bad;
  logic [SLOT_COUNT-1:0]            rel_mask;

  ffcsa_fit #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_fit (
    .busy_map   (map_r),
    .run_len    (rd_data_r.size),
    .found      (fit_found),
    .first_idx  (fit_idx),
    .claim_mask (fit_claim)
  );

  assign busy            = (state_r != ffcsa_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_grant_tag   = out_r.tag;
  assign out_grant_start = out_r.pos;
  assign out_last_of_run = out_last_r;

  assign tail_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign mem_waddr = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     QW'(tail_sum - SUM_W'(QUEUE_DEPTH)) : QW'(tail_sum);
  assign rel_end   = 7'(rel_start_r) + 7'(cmd_r.size);
  assign rsv_bad   = (cmd_r.size == '0) || (7'(cmd_r.size) > 7'(SLOT_COUNT));
  assign rel_bad   = (cmd_r.size == '0) || (rel_end > 7'(SLOT_COUNT));

  always_comb begin
    for (int j = 0; j < SLOT_COUNT; j++) begin
      rel_mask[j] = (j >= int'(rel_start_r)) && (j < int'(rel_end));
    end
  end

  // pending queue memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= cmd_r;
    end
    if (mem_re) begin
      rd_data_r <= mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ffcsa_pkg::ST_IDLE;
      map_r        <= '0;
      head_r       <= '0;
      count_r      <= '0;
      run_r        <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      map_r        <= map_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      run_r        <= run_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r       <= hold_nxt;
    out_status_r <= out_status_nxt;
    out_r        <= out_nxt;
    out_last_r   <= out_last_nxt;
    if (start && !busy) begin
      op_r        <= in_opcode;
      cmd_r.tag   <= in_requester_tag;
      cmd_r.size  <= in_request_size;
      rel_start_r <= in_release_start;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    map_nxt        = map_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    run_nxt        = run_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    unique case (state_r)
      ffcsa_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = ffcsa_pkg::ST_EXEC;
        end
      end

      ffcsa_pkg::ST_EXEC: begin
        run_nxt   = '0;
        state_nxt = ffcsa_pkg::ST_READ;
        if (op_r == ffcsa_pkg::OP_RESERVE) begin
          if (rsv_bad || (count_r >= CW'(QUEUE_DEPTH))) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = rsv_bad ? ffcsa_pkg::STATUS_BAD : ffcsa_pkg::STATUS_FULL;
            out_nxt.tag    = cmd_r.tag;
            out_nxt.pos    = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = ffcsa_pkg::ST_IDLE;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end else begin
          if (rel_bad) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ffcsa_pkg::STATUS_BAD;
            out_nxt.tag    = cmd_r.tag;
            out_nxt.pos    = '0;
            out_last_nxt   = 1'b1;
            state_nxt      = ffcsa_pkg::ST_IDLE;
          end else begin
            map_nxt = map_r & ~rel_mask;
          end
        end
      end

      ffcsa_pkg::ST_READ: begin
        if ((count_r == '0) || (run_r == ffcsa_pkg::RUN_W'(ffcsa_pkg::MAX_RUN))) begin
          if (hold_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ffcsa_pkg::STATUS_GRANTED;
            out_nxt        = hold_r;
            out_last_nxt   = 1'b1;
          end
          hold_valid_nxt = 1'b0;
          state_nxt      = ffcsa_pkg::ST_IDLE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ffcsa_pkg::ST_FIT;
        end
      end

      ffcsa_pkg::ST_FIT: begin
        if (hold_valid_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ffcsa_pkg::STATUS_GRANTED;
          out_nxt        = hold_r;
          out_last_nxt   = !fit_found;
        end
        if (fit_found) begin
          map_nxt        = map_r | fit_claim;
          hold_valid_nxt = 1'b1;
          hold_nxt.tag   = rd_data_r.tag;
          hold_nxt.pos   = ffcsa_pkg::POS_W'(fit_idx);
          head_nxt       = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          count_nxt      = count_r - 1'b1;
          run_nxt        = run_r + 1'b1;
          state_nxt      = ffcsa_pkg::ST_READ;
        end else begin
          hold_valid_nxt = 1'b0;
          state_nxt      = ffcsa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ffcsa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int SLOTS        = 16;
  localparam int DEPTH        = 8;
  localparam int RANDOM_ITEMS = 238;
  localparam int CALM_ITEMS   = 40;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [1:0]                  status;
    logic [ffcsa_pkg::TAG_W-1:0] tag;
    logic [ffcsa_pkg::POS_W-1:0] pos;
    logic                        last;
  } alloc_result_t;

  typedef struct {
    int pos;
    int len;
  } slot_block_t;

  class slot_allocation_checker;
    logic [SLOTS-1:0]       busy_map;
    ffcsa_pkg::pend_entry_t wait_fifo[DEPTH];
    int                     wait_head;
    int                     wait_count;
    alloc_result_t          awaited_results[$];
    slot_block_t            held_blocks[$];
    int                     errors;

    function new();
      busy_map   = '0;
      wait_head  = 0;
      wait_count = 0;
      errors     = 0;
    endfunction

    function int first_free_run(int len);
      logic [63:0] span;
      span = (64'd1 << len) - 64'd1;
      for (int i = 0; i + len <= SLOTS; i++) begin
        if ((64'(busy_map) & (span << i)) == 64'd0) return i;
      end
      return -1;
    endfunction

    function void accept_command(logic op, logic [ffcsa_pkg::TAG_W-1:0] tag,
                                 logic [ffcsa_pkg::SIZE_W-1:0] size,
                                 logic [ffcsa_pkg::POS_W-1:0] rs);
      alloc_result_t run[$];
      alloc_result_t res;
      slot_block_t   blk;
      logic [63:0]   span;
      int            len;
      int            first;
      int            pos;
      len        = int'(size);
      first      = int'(rs);
      res.status = ffcsa_pkg::STATUS_BAD;
      res.tag    = tag;
      res.pos    = '0;
      res.last   = 1'b1;
      if (len == 0 || (op == ffcsa_pkg::OP_RESERVE && len > SLOTS) ||
          (op == ffcsa_pkg::OP_RELEASE && first + len > SLOTS)) begin
        awaited_results.push_back(res);
        return;
      end
      if (op == ffcsa_pkg::OP_RESERVE) begin
        if (wait_count >= DEPTH) begin
          res.status = ffcsa_pkg::STATUS_FULL;
          awaited_results.push_back(res);
          return;
        end
        wait_fifo[(wait_head + wait_count) % DEPTH].tag  = tag;
        wait_fifo[(wait_head + wait_count) % DEPTH].size = size;
        wait_count++;
      end else begin
        span     = ((64'd1 << len) - 64'd1) << first;
        busy_map = busy_map & ~span[SLOTS-1:0];
      end
      // in-order drain, head blocks everything behind it
      while (wait_count > 0 && run.size() < ffcsa_pkg::MAX_RUN) begin
        len = int'(wait_fifo[wait_head].size);
        pos = first_free_run(len);
        if (pos < 0) break;
        span       = ((64'd1 << len) - 64'd1) << pos;
        busy_map   = busy_map | span[SLOTS-1:0];
        res.status = ffcsa_pkg::STATUS_GRANTED;
        res.tag    = wait_fifo[wait_head].tag;
        res.pos    = pos[ffcsa_pkg::POS_W-1:0];
        res.last   = 1'b0;
        run.push_back(res);
        blk.pos = pos;
        blk.len = len;
        held_blocks.push_back(blk);
        wait_head = (wait_head + 1) % DEPTH;
        wait_count--;
      end
      foreach (run[i]) begin
        res      = run[i];
        res.last = (i == run.size() - 1);
        awaited_results.push_back(res);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_grant(logic [1:0] status, logic [ffcsa_pkg::TAG_W-1:0] tag,
                              logic [ffcsa_pkg::POS_W-1:0] pos, logic last);
      alloc_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, %s %0d tag %0d start %0d last %0d",
                 $time, "actual status", status, tag, pos, last);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("status", 8'(want.status), 8'(status));
      compare_field("grant_tag", want.tag, tag);
      compare_field("grant_start", 8'(want.pos), 8'(pos));
      compare_field("last_of_run", 8'(want.last), 8'(last));
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic                         in_opcode;
  logic [ffcsa_pkg::TAG_W-1:0]  in_requester_tag;
  logic [ffcsa_pkg::SIZE_W-1:0] in_request_size;
  logic [ffcsa_pkg::POS_W-1:0]  in_release_start;
  logic                         out_valid;
  logic [1:0]                   out_status;
  logic [ffcsa_pkg::TAG_W-1:0]  out_grant_tag;
  logic [ffcsa_pkg::POS_W-1:0]  out_grant_start;
  logic                         out_last_of_run;

  slot_allocation_checker sb;
  int                     gap_pct;
  int                     cycles = 0;

  first_fit_contiguous_slot_allocator #(
    .SLOT_COUNT (SLOTS),
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_requester_tag(in_requester_tag),
    .in_request_size (in_request_size),
    .in_release_start(in_release_start),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_grant_tag   (out_grant_tag),
    .out_grant_start (out_grant_start),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("first_fit_contiguous_slot_allocator regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_grant(out_status, out_grant_tag, out_grant_start, out_last_of_run);
    end
  end

  task automatic send_command(logic op, logic [ffcsa_pkg::TAG_W-1:0] tag,
                              logic [ffcsa_pkg::SIZE_W-1:0] size,
                              logic [ffcsa_pkg::POS_W-1:0] rs);
    if ($urandom_range(1, 100) <= gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start            <= 1'b1;
    in_opcode        <= op;
    in_requester_tag <= tag;
    in_request_size  <= size;
    in_release_start <= rs;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.accept_command(op, tag, size, rs);
  endtask

  task automatic send_random_command();
    logic                         op;
    logic [ffcsa_pkg::TAG_W-1:0]  tag;
    logic [ffcsa_pkg::SIZE_W-1:0] size;
    logic [ffcsa_pkg::POS_W-1:0]  rs;
    int                           roll;
    int                           pick;
    roll = $urandom_range(0, 99);
    tag  = ffcsa_pkg::TAG_W'($urandom_range(0, 255));
    rs   = ffcsa_pkg::POS_W'($urandom_range(0, 15));
    op   = ffcsa_pkg::OP_RESERVE;
    if (roll < 55) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) size = ffcsa_pkg::SIZE_W'($urandom_range(1, 4));
      else if (pick < 93) size = ffcsa_pkg::SIZE_W'($urandom_range(5, 16));
      else if (pick < 96) size = '0;
      else size = ffcsa_pkg::SIZE_W'($urandom_range(17, 31));
    end else if (roll < 90 && sb.held_blocks.size() > 0) begin
      // free a block that is actually held
      pick = $urandom_range(0, sb.held_blocks.size() - 1);
      op   = ffcsa_pkg::OP_RELEASE;
      rs   = ffcsa_pkg::POS_W'(sb.held_blocks[pick].pos);
      size = ffcsa_pkg::SIZE_W'(sb.held_blocks[pick].len);
      sb.held_blocks.delete(pick);
    end else begin
      op   = ffcsa_pkg::OP_RELEASE;
      size = ffcsa_pkg::SIZE_W'($urandom_range(0, 17));
    end
    send_command(op, tag, size, rs);
  endtask

  initial begin
    sb               = new();
    gap_pct          = 30;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_opcode        <= ffcsa_pkg::OP_RESERVE;
    in_requester_tag <= '0;
    in_request_size  <= '0;
    in_release_start <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bad sizes, whole map, queue fill and overflow
    send_command(ffcsa_pkg::OP_RESERVE, 8'd0, 5'd0, 4'd0);
    send_command(ffcsa_pkg::OP_RESERVE, 8'd255, 5'd31, 4'd15);
    send_command(ffcsa_pkg::OP_RESERVE, 8'd3, 5'd17, 4'd0);
    send_command(ffcsa_pkg::OP_RESERVE, 8'd1, 5'd16, 4'd0);
    for (int i = 0; i < DEPTH; i++) begin
      send_command(ffcsa_pkg::OP_RESERVE, ffcsa_pkg::TAG_W'(16 + i), 5'd1, 4'd0);
    end
    send_command(ffcsa_pkg::OP_RESERVE, 8'd30, 5'd1, 4'd0);
    // bad releases, then a full release that drains a maximal run
    send_command(ffcsa_pkg::OP_RELEASE, 8'd40, 5'd2, 4'd15);
    send_command(ffcsa_pkg::OP_RELEASE, 8'd41, 5'd0, 4'd3);
    send_command(ffcsa_pkg::OP_RELEASE, 8'd42, 5'd16, 4'd0);
    send_command(ffcsa_pkg::OP_RELEASE, 8'd43, 5'd8, 4'd8);
    // blocked head holds back a request that would fit
    send_command(ffcsa_pkg::OP_RESERVE, 8'd50, 5'd9, 4'd0);
    send_command(ffcsa_pkg::OP_RESERVE, 8'd51, 5'd1, 4'd0);
    send_command(ffcsa_pkg::OP_RELEASE, 8'd52, 5'd1, 4'd15);
    send_command(ffcsa_pkg::OP_RELEASE, 8'd53, 5'd8, 4'd0);
    send_command(ffcsa_pkg::OP_RELEASE, 8'd54, 5'd16, 4'd0);
    sb.held_blocks.delete();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 25;
          default: gap_pct = 60;
        endcase
      end
      if (n >= RANDOM_ITEMS - CALM_ITEMS) gap_pct = 0;
      send_random_command();
    end
    start <= 1'b0;

    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("first_fit_contiguous_slot_allocator regression: pass");
    end else begin
      $display("first_fit_contiguous_slot_allocator regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/ffcsa_pkg.sv
sv/ffcsa_fit.sv
sv/first_fit_contiguous_slot_allocator.sv
verif/tb_top.sv
